/* rtl/core/rmt_pkg.sv */
package rmt_pkg;

   // Default number of cells in the sorted row
   localparam int CAPACITY_DEF = 64;

   // Field widths
   localparam int SAMPLE_W = 32;
   localparam int MEDIAN_W = 33;
   localparam int COUNT_OUT_W = 7;

   // Cells folded into one register of the median reduction
   localparam int GROUP_SIZE = 8;

   // Request kinds
   localparam logic KIND_ADD = 1'b0;
   localparam logic KIND_CLEAR = 1'b1;

   typedef struct packed {
      logic kind;
      logic signed [SAMPLE_W-1:0] sample;
   } req_type;

   typedef struct packed {
      logic signed [MEDIAN_W-1:0] median_doubled;
      logic [COUNT_OUT_W-1:0] stored_count;
      logic median_valid;
      logic sample_dropped;
   } rsp_type;

   // Broadcast from the row controller to every cell
   typedef struct packed {
      logic load;
      logic odd;
      logic signed [SAMPLE_W-1:0] sample;
   } cell_ctrl_type;

endpackage

/* rtl/core/rmt_cell.sv */
module rmt_cell #(
   parameter int INDEX = 0,
   parameter int COUNT_W = 7
) (
   input  logic clock,
   input  rmt_pkg::cell_ctrl_type ctrl,
   input  logic [COUNT_W-1:0] count,
   input  logic [COUNT_W-1:0] half,
   input  logic signed [rmt_pkg::SAMPLE_W-1:0] left_value,
   input  logic left_gt,
   output logic signed [rmt_pkg::SAMPLE_W-1:0] value,
   output logic gt,
   output logic [rmt_pkg::SAMPLE_W-1:0] lo_value,
   output logic [rmt_pkg::SAMPLE_W-1:0] hi_value
);

   localparam logic [COUNT_W-1:0] MY_INDEX = COUNT_W'(INDEX);
   localparam logic [COUNT_W-1:0] NEXT_INDEX = COUNT_W'(INDEX + 1);

   logic signed [rmt_pkg::SAMPLE_W-1:0] value_ff;
   logic signed [rmt_pkg::SAMPLE_W-1:0] value_in;
   logic occupied;
   logic lo_pick;
   logic hi_pick;

   // An empty cell counts as larger than any sample
   assign occupied = MY_INDEX < count;
   assign gt = !occupied || (value_ff > ctrl.sample);

   // Shift in from the left neighbor, or take the new word where it lands
   always_comb begin
      value_in = value_ff;
      if (ctrl.load && gt) begin
         value_in = left_gt ? left_value : ctrl.sample;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   // Offer this cell's value when it sits at one of the middle places
   assign hi_pick = occupied && (MY_INDEX == half);
   assign lo_pick = occupied && (ctrl.odd ? (MY_INDEX == half) : (NEXT_INDEX == half));
   assign lo_value = lo_pick ? value_ff : '0;
   assign hi_value = hi_pick ? value_ff : '0;
   assign value = value_ff;

endmodule

/* rtl/core/rmt_median.sv */
module rmt_median #(
   parameter int CAPACITY = rmt_pkg::CAPACITY_DEF
) (
   input  logic clock,
   input  logic [rmt_pkg::SAMPLE_W-1:0] lo_value [CAPACITY],
   input  logic [rmt_pkg::SAMPLE_W-1:0] hi_value [CAPACITY],
   output logic signed [rmt_pkg::MEDIAN_W-1:0] median_doubled
);

   localparam int GROUPS = (CAPACITY + rmt_pkg::GROUP_SIZE - 1) / rmt_pkg::GROUP_SIZE;

   logic [rmt_pkg::SAMPLE_W-1:0] lo_grp_ff [GROUPS];
   logic [rmt_pkg::SAMPLE_W-1:0] hi_grp_ff [GROUPS];
   logic [rmt_pkg::SAMPLE_W-1:0] lo_grp_in [GROUPS];
   logic [rmt_pkg::SAMPLE_W-1:0] hi_grp_in [GROUPS];
   logic [rmt_pkg::SAMPLE_W-1:0] lo_all;
   logic [rmt_pkg::SAMPLE_W-1:0] hi_all;

   // Fold each group of cells; at most one cell per side is nonzero
   always_comb begin
      for (int g = 0; g < GROUPS; g++) begin
         lo_grp_in[g] = '0;
         hi_grp_in[g] = '0;
         for (int j = 0; j < rmt_pkg::GROUP_SIZE; j++) begin
            if (g * rmt_pkg::GROUP_SIZE + j < CAPACITY) begin
               lo_grp_in[g] = lo_grp_in[g] | lo_value[g * rmt_pkg::GROUP_SIZE + j];
               hi_grp_in[g] = hi_grp_in[g] | hi_value[g * rmt_pkg::GROUP_SIZE + j];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      lo_grp_ff <= lo_grp_in;
      hi_grp_ff <= hi_grp_in;
   end

   // Fold the groups and add the two middle values
   always_comb begin
      lo_all = '0;
      hi_all = '0;
      for (int g = 0; g < GROUPS; g++) begin
         lo_all = lo_all | lo_grp_ff[g];
         hi_all = hi_all | hi_grp_ff[g];
      end
   end

   assign median_doubled = {lo_all[rmt_pkg::SAMPLE_W-1], lo_all}
                         + {hi_all[rmt_pkg::SAMPLE_W-1], hi_all};

endmodule

/* rtl/core/running_median_tracker_unit.sv */
// The result strobe rsp_valid follows an accept through stage1_ff, stage2_ff and rsp_valid_ff.
// No new word is taken while the last one is still in the median fold behind the row (busy).
// The sorted row itself inserts a sample by compare-and-shift in every cell.
// Reset clears the sample count and the pipeline; cell contents stay undefined until written.
// Results are shown for one cycle only: the receiver cannot stall.
module running_median_tracker_unit #(
   parameter int CAPACITY = rmt_pkg::CAPACITY_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  rmt_pkg::req_type req_data,
   output logic rsp_valid,
   output rmt_pkg::rsp_type rsp_data
);

   localparam int COUNT_W = $clog2(CAPACITY + 1);
   localparam logic [COUNT_W-1:0] FULL = COUNT_W'(CAPACITY);

   logic accept;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic [COUNT_W-1:0] half;
   logic stage1_ff;
   logic stage2_ff;
   logic rsp_valid_ff;
   logic dropped_ff;
   logic dropped_in;
   logic load;
   rmt_pkg::rsp_type rsp_ff;
   rmt_pkg::cell_ctrl_type ctrl;

   logic signed [rmt_pkg::SAMPLE_W-1:0] cell_value [CAPACITY];
   logic cell_gt [CAPACITY];
   logic [rmt_pkg::SAMPLE_W-1:0] lo_value [CAPACITY];
   logic [rmt_pkg::SAMPLE_W-1:0] hi_value [CAPACITY];
   logic signed [rmt_pkg::MEDIAN_W-1:0] median_doubled;

   assign accept = start && !busy;
   assign busy = stage1_ff || stage2_ff;

   // Decide the count and whether the word enters the row
   always_comb begin
      count_in = count_ff;
      dropped_in = dropped_ff;
      load = 1'b0;
      if (accept) begin
         dropped_in = 1'b0;
         if (req_data.kind == rmt_pkg::KIND_CLEAR) begin
            count_in = '0;
         end else if (count_ff == FULL) begin
            dropped_in = 1'b1;
         end else begin
            count_in = count_ff + COUNT_W'(1);
            load = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         stage1_ff <= 1'b0;
         stage2_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         stage1_ff <= accept;
         stage2_ff <= stage1_ff;
         rsp_valid_ff <= stage2_ff;
      end
   end

   always_ff @(posedge clock) begin
      dropped_ff <= dropped_in;
   end

   // Broadcast to the row
   assign half = count_ff >> 1;
   assign ctrl.load = load;
   assign ctrl.odd = count_ff[0];
   assign ctrl.sample = req_data.sample;

   // Sorted row, ascending from cell 0
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [rmt_pkg::SAMPLE_W-1:0] left_value;
      logic left_gt;

      if (i == 0) begin : g_first
         assign left_value = '0;
         assign left_gt = 1'b0;
      end else begin : g_rest
         assign left_value = cell_value[i-1];
         assign left_gt = cell_gt[i-1];
      end

      rmt_cell #(
         .INDEX(i),
         .COUNT_W(COUNT_W)
      ) u_cell (
         .clock(clock),
         .ctrl(ctrl),
         .count(count_ff),
         .half(half),
         .left_value(left_value),
         .left_gt(left_gt),
         .value(cell_value[i]),
         .gt(cell_gt[i]),
         .lo_value(lo_value[i]),
         .hi_value(hi_value[i])
      );
   end

   rmt_median #(
      .CAPACITY(CAPACITY)
   ) u_median (
      .clock(clock),
      .lo_value(lo_value),
      .hi_value(hi_value),
      .median_doubled(median_doubled)
   );

   // Capture the result word
   always_ff @(posedge clock) begin
      if (stage2_ff) begin
         rsp_ff.median_doubled <= median_doubled;
         rsp_ff.stored_count <= rmt_pkg::COUNT_OUT_W'(count_ff);
         rsp_ff.median_valid <= count_ff != '0;
         rsp_ff.sample_dropped <= dropped_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset) count_ff <= FULL)
      else $error("sample count above capacity");

   assert property (@(posedge clock) disable iff (reset) accept |=> busy)
      else $error("busy not raised after accept");

   assert property (@(posedge clock) disable iff (reset)
      $onehot0({stage1_ff, stage2_ff, rsp_valid_ff}))
      else $error("more than one word in flight");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.median_valid == (count_ff != '0)))
      else $error("median valid disagrees with count");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.sample_dropped) |-> (count_ff == FULL))
      else $error("word dropped while row not full");
`endif

endmodule
